/* hw/rtl/tpwl_pkg.sv */
// ----------------------------------------------------------------------------
// tpwl_pkg
// Shared types, constants and segment tables for the piecewise-linear tanh core.
// ----------------------------------------------------------------------------
package tpwl_pkg;

    localparam int unsigned InWidth    = 32;
    localparam int unsigned OutWidth   = 16;
    localparam int unsigned SegShift   = 12;
    localparam int unsigned SegLast    = 40;
    localparam int unsigned SegWidth   = InWidth - SegShift;
    localparam int unsigned SegIdxW    = 6;
    localparam int unsigned OffWidth   = SegShift;
    localparam int unsigned BaseWidth  = 15;
    localparam int unsigned SlopeWidth = 12;
    localparam int unsigned FracShift  = 16;
    localparam int unsigned ScaledW    = OffWidth + 4;
    localparam int unsigned ProdWidth  = ScaledW + SlopeWidth;
    localparam int unsigned AccWidth   = BaseWidth + FracShift + 1;
    localparam int unsigned MagWidth   = OutWidth - 1;

    localparam logic [MagWidth-1:0] SatMag = {MagWidth{1'b1}};

    // Looked-up segment word, front half to back half
    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic                  sat;
        logic [BaseWidth-1:0]  base;
        logic [SlopeWidth-1:0] slope;
        logic [OffWidth-1:0]   offset;
    } t_seg;

    function automatic logic [BaseWidth-1:0] seg_base(input logic [SegIdxW-1:0] idx);
        logic [BaseWidth-1:0] v;
        case (idx)
            6'd0:  v = 15'd0;      6'd1:  v = 15'd4075;   6'd2:  v = 15'd8025;
            6'd3:  v = 15'd11743;  6'd4:  v = 15'd15143;  6'd5:  v = 15'd18173;
            6'd6:  v = 15'd20813;  6'd7:  v = 15'd23066;  6'd8:  v = 15'd24956;
            6'd9:  v = 15'd26519;  6'd10: v = 15'd27797;  6'd11: v = 15'd28830;
            6'd12: v = 15'd29660;  6'd13: v = 15'd30322;  6'd14: v = 15'd30847;
            6'd15: v = 15'd31262;  6'd16: v = 15'd31589;  6'd17: v = 15'd31846;
            6'd18: v = 15'd32048;  6'd19: v = 15'd32206;  6'd20: v = 15'd32329;
            6'd21: v = 15'd32426;  6'd22: v = 15'd32501;  6'd23: v = 15'd32560;
            6'd24: v = 15'd32606;  6'd25: v = 15'd32642;  6'd26: v = 15'd32670;
            6'd27: v = 15'd32691;  6'd28: v = 15'd32708;  6'd29: v = 15'd32721;
            6'd30: v = 15'd32732;  6'd31: v = 15'd32740;  6'd32: v = 15'd32746;
            6'd33: v = 15'd32751;  6'd34: v = 15'd32755;  6'd35: v = 15'd32758;
            6'd36: v = 15'd32760;  6'd37: v = 15'd32762;  6'd38: v = 15'd32763;
            6'd39: v = 15'd32764;  6'd40: v = 15'd32765;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SlopeWidth-1:0] seg_slope(input logic [SegIdxW-1:0] idx);
        logic [SlopeWidth-1:0] v;
        case (idx)
            6'd0:  v = 12'd4075;  6'd1:  v = 12'd3950;  6'd2:  v = 12'd3718;
            6'd3:  v = 12'd3400;  6'd4:  v = 12'd3030;  6'd5:  v = 12'd2640;
            6'd6:  v = 12'd2253;  6'd7:  v = 12'd1890;  6'd8:  v = 12'd1563;
            6'd9:  v = 12'd1278;  6'd10: v = 12'd1033;  6'd11: v = 12'd830;
            6'd12: v = 12'd662;   6'd13: v = 12'd525;   6'd14: v = 12'd415;
            6'd15: v = 12'd327;   6'd16: v = 12'd257;   6'd17: v = 12'd202;
            6'd18: v = 12'd158;   6'd19: v = 12'd123;   6'd20: v = 12'd97;
            6'd21: v = 12'd75;    6'd22: v = 12'd59;    6'd23: v = 12'd46;
            6'd24: v = 12'd36;    6'd25: v = 12'd28;    6'd26: v = 12'd21;
            6'd27: v = 12'd17;    6'd28: v = 12'd13;    6'd29: v = 12'd11;
            6'd30: v = 12'd8;     6'd31: v = 12'd6;     6'd32: v = 12'd5;
            6'd33: v = 12'd4;     6'd34: v = 12'd3;     6'd35: v = 12'd2;
            6'd36: v = 12'd2;     6'd37: v = 12'd1;     6'd38: v = 12'd1;
            6'd39: v = 12'd1;     6'd40: v = 12'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/tpwl_front.sv */
// ----------------------------------------------------------------------------
// tpwl_front
// Magnitude stage and segment lookup stage: two registered steps.
// ----------------------------------------------------------------------------
module tpwl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [tpwl_pkg::InWidth-1:0] i_activation,
    output tpwl_pkg::t_seg                      o_seg
);
    import tpwl_pkg::*;

    logic                r_mag_valid;
    logic                r_mag_neg;
    logic [InWidth-1:0]  r_mag;
    logic [InWidth-1:0]  n_mag;
    logic [SegWidth-1:0] seg_full;
    logic                seg_over;
    logic [SegIdxW-1:0]  seg_idx;
    t_seg                r_seg;
    t_seg                n_seg;

    // Two's complement magnitude; the most negative input gives 2^31 unsigned
    assign n_mag = i_activation[InWidth-1] ? (~i_activation + 1'b1) : i_activation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_valid <= 1'b0;
        end else begin
            r_mag_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_neg <= i_activation[InWidth-1];
        r_mag     <= n_mag;
    end

    assign seg_full = r_mag[InWidth-1:SegShift];
    assign seg_over = seg_full > SegWidth'(SegLast);
    assign seg_idx  = seg_full[SegIdxW-1:0];

    always_comb begin
        n_seg        = '0;
        n_seg.valid  = r_mag_valid;
        n_seg.neg    = r_mag_neg;
        n_seg.sat    = seg_over;
        n_seg.base   = seg_base(seg_idx);
        n_seg.slope  = seg_slope(seg_idx);
        n_seg.offset = r_mag[OffWidth-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= '0;
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

/* hw/rtl/tpwl_interp.sv */
// ----------------------------------------------------------------------------
// tpwl_interp
// Slope multiply stage, then base add, saturation and sign restore.
// ----------------------------------------------------------------------------
module tpwl_interp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tpwl_pkg::t_seg                       i_seg,
    output logic                                 o_valid,
    output logic signed [tpwl_pkg::OutWidth-1:0] o_result
);
    import tpwl_pkg::*;

    logic                 r_mul_valid;
    logic                 r_mul_neg;
    logic                 r_mul_sat;
    logic [BaseWidth-1:0] r_mul_base;
    logic [ProdWidth-1:0] r_prod;
    logic [ProdWidth-1:0] n_prod;
    logic [ScaledW-1:0]   scaled_off;
    logic [AccWidth-1:0]  acc;
    logic [MagWidth-1:0]  mag;
    logic [OutWidth-1:0]  n_result;
    logic                 r_out_valid;
    logic [OutWidth-1:0]  r_result;

    assign scaled_off = {i_seg.offset, 4'b0000};
    assign n_prod     = ProdWidth'(scaled_off) * ProdWidth'(i_seg.slope);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else begin
            r_mul_valid <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_neg  <= i_seg.neg;
        r_mul_sat  <= i_seg.sat;
        r_mul_base <= i_seg.base;
        r_prod     <= n_prod;
    end

    // Sum stays below 2^31, so no wrap before the fraction is dropped
    assign acc = {1'b0, r_mul_base, {FracShift{1'b0}}} + AccWidth'(r_prod);
    assign mag = r_mul_sat ? SatMag : acc[FracShift +: MagWidth];
    assign n_result = r_mul_neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

/* hw/rtl/tanh_piecewise_linear_lut_core.sv */
// ----------------------------------------------------------------------------
// tanh_piecewise_linear_lut_core
// Piecewise-linear tanh of a signed 17.15 word, result in signed 1.15.
//
//   Channel   Direction  Handshake           Payload
//   input     in         start / busy        i_activation [31:0] signed
//   result    out        o_result_valid      o_result     [15:0] signed
//
// One word per cycle enters; its result follows it through the stages below.
// Stages: magnitude, segment table lookup, slope multiply, add and sign.
// busy is tied low: the pipeline never backs up and nothing stalls it.
// The receiver cannot stall; each result is presented for one cycle only.
// Synchronous active-low reset clears the valid bits of all stages.
// ----------------------------------------------------------------------------
module tanh_piecewise_linear_lut_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [tpwl_pkg::InWidth-1:0]  i_activation,
    output logic                                 o_result_valid,
    output logic signed [tpwl_pkg::OutWidth-1:0] o_result
);
    import tpwl_pkg::*;

    t_seg seg;

    assign busy = 1'b0;

    tpwl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_activation (i_activation),
        .o_seg        (seg)
    );

    tpwl_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seg    (seg),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

    localparam logic signed [InWidth-1:0] SatPos = ((SegLast + 1) << SegShift);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_result_valid)
        else $error("accepted word did not produce a result after four cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##4 !o_result_valid)
        else $error("result strobe without an accepted word");

    a_sat_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_activation >= SatPos)) |-> ##4 (o_result == 16'sd32767))
        else $error("large positive input did not saturate");

    a_sat_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_activation <= -SatPos)) |-> ##4 (o_result == -16'sd32767))
        else $error("large negative input did not saturate");

endmodule
